FILE: sv/ipq_pkg.sv
package ipq_pkg;

  // Default sizes
  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_VALUE_WIDTH = 32;

  // Operation codes
  localparam logic [1:0] MODE_INSERT  = 2'd0;
  localparam logic [1:0] MODE_EXTRACT = 2'd1;
  localparam logic [1:0] MODE_CHANGE  = 2'd2;
  localparam logic [1:0] MODE_READ    = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  // One result word
  typedef struct packed {
    logic [31:0] result_value;
    logic [5:0]  result_slot;
    logic [1:0]  status;
    logic [6:0]  entries;
  } ipq_res_t;

endpackage

FILE: sv/ipq_ctrl.sv
module ipq_ctrl #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        mode,
  input  logic [5:0]        slot,
  input  logic [31:0]       value,
  output logic              idle,
  output logic              done,
  input  logic              take,
  output ipq_pkg::ipq_res_t res
);
  import ipq_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int POS_W = $clog2(CAPACITY + 1);
  localparam int VW    = VALUE_WIDTH;
  localparam int SW    = VW + POS_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_VAL, S_CH_POS, S_UP_RD, S_UP_PS, S_UP_CMP, S_UP_END,
    S_EX_TOP, S_EX_VAL, S_EX_LV, S_DN_RD, S_DN_L, S_DN_LV, S_DN_RV,
    S_DN_CMP, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            mode_r, mode_nxt;
  logic [POS_W-1:0]      cnt_r, cnt_nxt;
  logic [CAPACITY-1:0]   used_r, used_nxt;
  logic [POS_W-1:0]      k_r, k_nxt;
  logic [POS_W:0]        j_r, j_nxt;
  logic [IDX_W-1:0]      x_r, x_nxt;
  logic [VW-1:0]         v_r, v_nxt;
  logic [IDX_W-1:0]      ps_r, ps_nxt;
  logic [IDX_W-1:0]      cs_r, cs_nxt;
  logic [VW-1:0]         cv_r, cv_nxt;
  logic [IDX_W-1:0]      rsl_r, rsl_nxt;
  logic                  moved_r, moved_nxt;
  logic [VW-1:0]         rv_r, rv_nxt;
  logic [IDX_W-1:0]      rs_r, rs_nxt;
  logic [1:0]            st_r, st_nxt;

  // Memories: heap order by position, slot word {value, position}
  logic [IDX_W-1:0] heap_mem [0:CAPACITY];
  logic [SW-1:0]    slot_mem [0:CAPACITY-1];

  logic             h_we;
  logic [POS_W-1:0] h_waddr, h_raddr;
  logic [IDX_W-1:0] h_wdata, h_rdata;
  logic             s_we;
  logic [IDX_W-1:0] s_waddr, s_raddr;
  logic [SW-1:0]    s_wdata, s_rdata;
  logic [VW-1:0]    s_rval;
  logic [POS_W-1:0] s_rpos;

  logic             slot_ok;
  logic [IDX_W-1:0] idx;
  logic             in_heap;

  assign s_rval = s_rdata[SW-1:POS_W];
  assign s_rpos = s_rdata[POS_W-1:0];

  assign slot_ok = 32'(slot) < 32'(CAPACITY);
  assign idx     = IDX_W'(slot);
  assign in_heap = slot_ok && used_r[idx];

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign res.result_value = 32'(rv_r);
  assign res.result_slot  = 6'(rs_r);
  assign res.status       = st_r;
  assign res.entries      = 7'(cnt_r);

  // Hold the heap order
  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_waddr] <= h_wdata;
    h_rdata <= heap_mem[h_raddr];
  end

  // Hold the slot words
  always_ff @(posedge clk) begin
    if (s_we) slot_mem[s_waddr] <= s_wdata;
    s_rdata <= slot_mem[s_raddr];
  end

  // Sequence one operation through the memories
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    used_nxt  = used_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    x_nxt     = x_r;
    v_nxt     = v_r;
    ps_nxt    = ps_r;
    cs_nxt    = cs_r;
    cv_nxt    = cv_r;
    rsl_nxt   = rsl_r;
    moved_nxt = moved_r;
    rv_nxt    = rv_r;
    rs_nxt    = rs_r;
    st_nxt    = st_r;
    h_we      = 1'b0;
    h_waddr   = k_r;
    h_wdata   = x_r;
    h_raddr   = '0;
    s_we      = 1'b0;
    s_waddr   = x_r;
    s_wdata   = {v_r, k_r};
    s_raddr   = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt  = mode;
          rv_nxt    = '0;
          rs_nxt    = '0;
          st_nxt    = ST_OK;
          moved_nxt = 1'b0;
          x_nxt     = idx;
          v_nxt     = VW'(value);
          case (mode)
            MODE_INSERT: begin
              if (cnt_r == POS_W'(CAPACITY)) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else if (!slot_ok || used_r[idx]) begin
                st_nxt    = ST_BAD;
                state_nxt = S_DONE;
              end else begin
                cnt_nxt       = cnt_r + 1'b1;
                used_nxt[idx] = 1'b1;
                k_nxt         = cnt_r + 1'b1;
                state_nxt     = S_UP_RD;
              end
            end
            MODE_EXTRACT: begin
              if (cnt_r == '0) begin
                st_nxt    = ST_EMPTY;
                state_nxt = S_DONE;
              end else begin
                h_raddr   = POS_W'(1);
                state_nxt = S_EX_TOP;
              end
            end
            MODE_CHANGE: begin
              if (!in_heap) begin
                st_nxt    = ST_BAD;
                state_nxt = S_DONE;
              end else begin
                s_raddr   = idx;
                state_nxt = S_CH_POS;
              end
            end
            default: begin
              if (!in_heap) begin
                st_nxt    = ST_BAD;
                state_nxt = S_DONE;
              end else begin
                s_raddr   = idx;
                state_nxt = S_RD_VAL;
              end
            end
          endcase
        end
      end
      S_RD_VAL: begin
        rv_nxt    = s_rval;
        state_nxt = S_DONE;
      end
      S_CH_POS: begin
        k_nxt     = s_rpos;
        state_nxt = S_UP_RD;
      end
      // Sift up: move the hole toward the root
      S_UP_RD: begin
        if (k_r == POS_W'(1)) begin
          state_nxt = S_UP_END;
        end else begin
          h_raddr   = k_r >> 1;
          state_nxt = S_UP_PS;
        end
      end
      S_UP_PS: begin
        ps_nxt    = h_rdata;
        s_raddr   = h_rdata;
        state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (v_r > s_rval) begin
          h_we      = 1'b1;
          h_waddr   = k_r;
          h_wdata   = ps_r;
          s_we      = 1'b1;
          s_waddr   = ps_r;
          s_wdata   = {s_rval, k_r};
          k_nxt     = k_r >> 1;
          moved_nxt = 1'b1;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_UP_END;
        end
      end
      S_UP_END: begin
        if (mode_r == MODE_CHANGE && !moved_r) begin
          state_nxt = S_DN_RD;
        end else begin
          h_we      = 1'b1;
          s_we      = 1'b1;
          state_nxt = S_DONE;
        end
      end
      // Extract: take the root, move the last entry to the top
      S_EX_TOP: begin
        rs_nxt    = h_rdata;
        s_raddr   = h_rdata;
        h_raddr   = cnt_r;
        state_nxt = S_EX_VAL;
      end
      S_EX_VAL: begin
        rv_nxt          = s_rval;
        used_nxt[rs_r]  = 1'b0;
        cnt_nxt         = cnt_r - 1'b1;
        x_nxt           = h_rdata;
        k_nxt           = POS_W'(1);
        s_raddr         = h_rdata;
        if (cnt_r == POS_W'(1)) state_nxt = S_DONE;
        else                    state_nxt = S_EX_LV;
      end
      S_EX_LV: begin
        v_nxt     = s_rval;
        state_nxt = S_DN_RD;
      end
      // Sift down: move the hole toward the leaves
      S_DN_RD: begin
        j_nxt = {k_r, 1'b0};
        if ({k_r, 1'b0} > {1'b0, cnt_r}) begin
          h_we      = 1'b1;
          s_we      = 1'b1;
          state_nxt = S_DONE;
        end else begin
          h_raddr   = POS_W'({k_r, 1'b0});
          state_nxt = S_DN_L;
        end
      end
      S_DN_L: begin
        cs_nxt    = h_rdata;
        s_raddr   = h_rdata;
        h_raddr   = POS_W'(j_r + 1'b1);
        state_nxt = S_DN_LV;
      end
      S_DN_LV: begin
        cv_nxt  = s_rval;
        rsl_nxt = h_rdata;
        if (j_r + 1'b1 <= {1'b0, cnt_r}) begin
          s_raddr   = h_rdata;
          state_nxt = S_DN_RV;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_RV: begin
        if (s_rval > cv_r) begin
          cs_nxt = rsl_r;
          cv_nxt = s_rval;
          j_nxt  = j_r + 1'b1;
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (v_r >= cv_r) begin
          h_we      = 1'b1;
          s_we      = 1'b1;
          state_nxt = S_DONE;
        end else begin
          h_we      = 1'b1;
          h_waddr   = k_r;
          h_wdata   = cs_r;
          s_we      = 1'b1;
          s_waddr   = cs_r;
          s_wdata   = {cv_r, k_r};
          k_nxt     = POS_W'(j_r);
          state_nxt = S_DN_RD;
        end
      end
      S_DONE: begin
        if (take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      used_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      used_r  <= used_nxt;
    end
    mode_r  <= mode_nxt;
    k_r     <= k_nxt;
    j_r     <= j_nxt;
    x_r     <= x_nxt;
    v_r     <= v_nxt;
    ps_r    <= ps_nxt;
    cs_r    <= cs_nxt;
    cv_r    <= cv_nxt;
    rsl_r   <= rsl_nxt;
    moved_r <= moved_nxt;
    rv_r    <= rv_nxt;
    rs_r    <= rs_nxt;
    st_r    <= st_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(CAPACITY))
    else $error("entry count above capacity");

  a_used_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == 32'(cnt_r))
    else $error("used slots disagree with entry count");

  a_no_idle_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (h_we || s_we) |-> (state_r != S_IDLE && state_r != S_DONE))
    else $error("memory write outside an operation");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && st_r == ST_FULL) |-> (32'(cnt_r) == 32'(CAPACITY)))
    else $error("full status with room left");
`endif

endmodule

FILE: sv/indexed_max_priority_queue_unit.sv
// Indexed max-priority queue. Values sit in numbered slots; a binary heap
// of slot numbers, kept in an on-chip memory, orders them by value.
// Input word (in_valid/in_stall): in_mode selects insert, extract maximum,
// change slot value or read slot value, with in_slot and in_value.
// Output word (out_valid/out_stall): one per input word, carrying the
// extracted or read value, the extracted slot, a status code and the
// number of heap entries after the operation.
// Insert sifts up, change sifts up or down, and extract sifts down; each
// level walked down reads two children through the single read port of each
// memory. The sift loop runs over the heap and slot memories.
// One item is in work at a time; the next word is accepted once the
// previous result is loaded into the output register.
// Reset clears the entry count and slot-in-use flags; the memories need no
// clearing. A stalled output word holds; the block finishes its current
// item and then stalls the input until the output register frees.
module indexed_max_priority_queue_unit #(
  parameter int CAPACITY    = ipq_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = ipq_pkg::DEF_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_slot,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_value,
  output logic [5:0]  out_result_slot,
  output logic [1:0]  out_status,
  output logic [6:0]  out_entries
);
  import ipq_pkg::*;

  logic     idle, done, take;
  ipq_res_t res;
  logic     out_valid_r, out_valid_nxt;
  ipq_res_t out_r, out_nxt;

  assign in_stall = !idle;
  assign take     = !out_valid_r || !out_stall;

  ipq_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_valid && idle),
    .mode  (in_mode),
    .slot  (in_slot),
    .value (in_value),
    .idle  (idle),
    .done  (done),
    .take  (take),
    .res   (res)
  );

  // Load the output word when free, drop it when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (done && take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_r.result_value;
  assign out_result_slot  = out_r.result_slot;
  assign out_status       = out_r.status;
  assign out_entries      = out_r.entries;

endmodule

FILE: tb/indexed_max_priority_queue_unit_tb.sv
module indexed_max_priority_queue_unit_tb;
  import ipq_pkg::*;

  localparam int CAP = 64;
  localparam int LIMIT_CYCLES = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [5:0]  in_slot;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_result_value;
  logic [5:0]  out_result_slot;
  logic [1:0]  out_status;
  logic [6:0]  out_entries;

  indexed_max_priority_queue_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_mode(in_mode), .in_slot(in_slot), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_result_slot(out_result_slot),
    .out_status(out_status), .out_entries(out_entries)
  );

  // Heap shadow: slot values, heap of slot numbers (root at 1), use flags
  logic [31:0] shadow_val [CAP];
  logic [5:0]  shadow_heap [CAP+1];
  logic        shadow_used [CAP];
  int          shadow_count;

  ipq_res_t    pending_results [$];
  int          errors;
  int          cycles = 0;
  bit          quiet;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function automatic logic [31:0] pos_val(int p);
    return shadow_val[shadow_heap[p]];
  endfunction

  function automatic void pos_swap(int a, int b);
    logic [5:0] t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic void heap_up(int k);
    while (k > 1 && pos_val(k) > pos_val(k/2)) begin
      pos_swap(k, k/2);
      k = k/2;
    end
  endfunction

  function automatic void heap_down(int k);
    int j;
    while (2*k <= shadow_count) begin
      j = 2*k;
      if (j+1 <= shadow_count && pos_val(j+1) > pos_val(j)) j++;
      if (pos_val(k) >= pos_val(j)) break;
      pos_swap(k, j);
      k = j;
    end
  endfunction

  // Compute the result of one word and advance the shadow heap
  function automatic ipq_res_t heap_apply(logic [1:0] m, logic [5:0] s, logic [31:0] v);
    ipq_res_t r;
    logic [5:0] top;
    r = '0;
    r.status = ST_OK;
    case (m)
      MODE_INSERT: begin
        if (shadow_count >= CAP) r.status = ST_FULL;
        else if (shadow_used[s]) r.status = ST_BAD;
        else begin
          shadow_count++;
          shadow_heap[shadow_count] = s;
          shadow_val[s] = v;
          shadow_used[s] = 1'b1;
          heap_up(shadow_count);
        end
      end
      MODE_EXTRACT: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else begin
          top = shadow_heap[1];
          r.result_value = shadow_val[top];
          r.result_slot = top;
          shadow_used[top] = 1'b0;
          pos_swap(1, shadow_count);
          shadow_count--;
          heap_down(1);
        end
      end
      MODE_CHANGE: begin
        if (!shadow_used[s]) r.status = ST_BAD;
        else begin
          shadow_val[s] = v;
          for (int p = 1; p <= shadow_count; p++) begin
            if (shadow_heap[p] == s) begin
              heap_up(p);
              heap_down(p);
              break;
            end
          end
        end
      end
      default: begin
        if (!shadow_used[s]) r.status = ST_BAD;
        else r.result_value = shadow_val[s];
      end
    endcase
    r.entries = shadow_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // Send one word, with random idle bursts ahead of it
  task automatic send_word(logic [1:0] m, logic [5:0] s, logic [31:0] v);
    if (!quiet && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 14)) @(posedge clk);
    in_valid <= 1'b1;
    in_mode  <= m;
    in_slot  <= s;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(heap_apply(m, s, v));
    // Drop valid for the cycle in which the block is busy anyway
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Check each accepted result word against the oldest expectation
  always @(posedge clk) begin
    ipq_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", out_result_value, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_result_value !== want.result_value)
          report_mismatch("result_value", out_result_value, want.result_value);
        if (out_result_slot !== want.result_slot)
          report_mismatch("result_slot", 32'(out_result_slot), 32'(want.result_slot));
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_entries !== want.entries)
          report_mismatch("entries", 32'(out_entries), 32'(want.entries));
      end
    end
  end

  // Receiver stall in random bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 14) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [5:0] pick_used();
    logic [5:0] s;
    s = 6'($urandom_range(0, CAP-1));
    if (shadow_count != 0) s = shadow_heap[$urandom_range(1, shadow_count)];
    return s;
  endfunction

  // Empty heap errors, extremes of value and slot, equal values
  task automatic test_directed();
    send_word(MODE_EXTRACT, 6'd0, 32'd0);
    send_word(MODE_READ, 6'd5, 32'd0);
    send_word(MODE_CHANGE, 6'd5, 32'd1);
    send_word(MODE_INSERT, 6'd0, 32'hFFFF_FFFF);
    send_word(MODE_INSERT, 6'd63, 32'd0);
    send_word(MODE_INSERT, 6'd63, 32'd9);
    send_word(MODE_INSERT, 6'd10, 32'd7);
    send_word(MODE_INSERT, 6'd11, 32'd7);
    send_word(MODE_INSERT, 6'd12, 32'd7);
    send_word(MODE_READ, 6'd0, 32'd0);
    send_word(MODE_READ, 6'd63, 32'd0);
    send_word(MODE_CHANGE, 6'd0, 32'd0);
    send_word(MODE_CHANGE, 6'd63, 32'hFFFF_FFFF);
    send_word(MODE_CHANGE, 6'd11, 32'hAAAA_5555);
    repeat (6) send_word(MODE_EXTRACT, 6'd0, 32'd0);
    send_word(MODE_READ, 6'd10, 32'd0);
  endtask

  // Fill the heap to capacity, overflow it, drain it
  task automatic test_full();
    for (int i = 0; i < CAP; i++) send_word(MODE_INSERT, i[5:0], $urandom_range(0, 20));
    send_word(MODE_INSERT, 6'd3, 32'd1);
    wait_drained();
    for (int i = 0; i < CAP + 1; i++) send_word(MODE_EXTRACT, 6'($urandom), $urandom);
  endtask

  // Random operation mix weighted toward useful words
  task automatic test_random(int n);
    logic [1:0]  m;
    logic [5:0]  s;
    logic [31:0] v;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      v = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : $urandom;
      s = 6'($urandom);
      if (r < 40) m = MODE_INSERT;
      else if (r < 65) m = MODE_EXTRACT;
      else if (r < 82) begin m = MODE_CHANGE; if (r < 79) s = pick_used(); end
      else begin m = MODE_READ; if (r < 96) s = pick_used(); end
      send_word(m, s, v);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_INSERT;
    in_slot = '0;
    in_value = '0;
    errors = 0;
    quiet = 1'b0;
    shadow_count = 0;
    for (int i = 0; i < CAP; i++) shadow_used[i] = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full();
    test_random(900);
    // Hold the sender until every result has come back
    wait_drained();
    test_random(150);
    quiet = 1'b1;
    test_random(100);

    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
